/* rtl/binary_to_decimal_ascii_macros.svh */
// Assertion macros used by the converter top module.
// No dependencies; include by bare file name inside a module body.
`ifndef BINARY_TO_DECIMAL_ASCII_MACROS_SVH
`define BINARY_TO_DECIMAL_ASCII_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define B2DA_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define B2DA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/b2da_pkg.sv */
// Shared types and constants for the binary to decimal ASCII converter.
// No dependencies.
`default_nettype none

package b2da_pkg;

    localparam int VALUE_W    = 32;
    localparam int FORMAT_W   = 8;
    localparam int CHAR_W     = 6;
    localparam int DIGIT_W    = 4;
    localparam int STEP_BITS  = 4;
    localparam int STEPS      = VALUE_W / STEP_BITS;
    localparam int STEP_CNT_W = $clog2(STEPS);

    localparam logic [FORMAT_W-1:0] FMT_DECIMAL = 8'd0;
    localparam logic [CHAR_W-1:0]   ASCII_ZERO  = 6'd48;
    localparam logic [CHAR_W-1:0]   ASCII_NINE  = 6'd57;

    typedef logic [DIGIT_W-1:0]   t_digit;
    typedef logic [STEP_BITS-1:0] t_step_bits;

    // control for the double-dabble digit cells
    typedef struct packed {
        logic clear;
        logic step;
    } t_dab_ctl;

    // control for the output shift cells
    typedef struct packed {
        logic load;
        logic shift;
    } t_shf_ctl;

endpackage

`default_nettype wire

/* rtl/binary_to_decimal_ascii.sv */
// Binary to decimal ASCII converter: a double-dabble digit chain takes four value
// bits per cycle, then a shift line sends one digit a cycle unless the output stalls.
// A new value can be converted while the shift line still sends the previous one;
// leading zeros are dropped but still take a shift position, and items in other
// formats are accepted and give no characters.
// Reset (synchronous, active low) empties the converter, shift line and output.
`default_nettype none

module binary_to_decimal_ascii #(
    parameter int DIGITS = 10
) (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    input  wire                                 i_valid,
    output logic                                o_stall,
    input  wire  [b2da_pkg::VALUE_W-1:0]        i_value,
    input  wire  [b2da_pkg::FORMAT_W-1:0]       i_format,
    output logic                                o_valid,
    input  wire                                 i_stall,
    output logic [b2da_pkg::CHAR_W-1:0]         o_digit_char,
    output logic                                o_last
);
    import b2da_pkg::*;

    localparam int POS_W = $clog2(DIGITS);
    localparam logic [POS_W-1:0] LAST_POS = POS_W'(DIGITS - 1);
    localparam logic [STEP_CNT_W-1:0] LAST_STEP = STEP_CNT_W'(STEPS - 1);

    // conversion side
    logic                  r_cv_busy;
    logic                  r_cv_full;
    logic [STEP_CNT_W-1:0] r_cv_cnt;
    logic [VALUE_W-1:0]    r_cv_val;

    // emit side
    logic                  r_em_active;
    logic                  r_em_seen;
    logic [POS_W-1:0]      r_em_pos;

    // output register
    logic                  r_out_valid;
    logic [CHAR_W-1:0]     r_out_char;
    logic                  r_out_last;

    t_dab_ctl   dab_ctl;
    t_shf_ctl   shf_ctl;
    t_step_bits w_feed;
    t_step_bits w_carry     [DIGITS];
    t_digit     w_dab_digit [DIGITS];
    t_digit     w_shf_digit [DIGITS];

    t_digit top_digit;
    logic   em_emit;
    logic   out_free;
    logic   em_adv;
    logic   em_done;
    logic   em_ready;
    logic   handoff;
    logic   cv_free;
    logic   in_acc;
    logic   start;

    // feed the most significant unconverted bits, first sub-step first
    always_comb begin
        for (int j = 0; j < STEP_BITS; j++) begin
            w_feed[j] = r_cv_val[VALUE_W-1-j];
        end
    end

    // cell 0 is the least significant digit; carries out of the top are dropped
    for (genvar k = 0; k < DIGITS; k++) begin : g_cells
        b2da_dabble_cell u_dab (
            .i_clk   (i_clk),
            .i_ctl   (dab_ctl),
            .i_bits  ((k == 0) ? w_feed : w_carry[(k == 0) ? 0 : k - 1]),
            .o_bits  (w_carry[k]),
            .o_digit (w_dab_digit[k])
        );

        b2da_shift_cell u_shf (
            .i_clk         (i_clk),
            .i_ctl         (shf_ctl),
            .i_load_digit  (w_dab_digit[k]),
            .i_shift_digit ((k == 0) ? t_digit'(0) : w_shf_digit[(k == 0) ? 0 : k - 1]),
            .o_digit       (w_shf_digit[k])
        );
    end

    always_comb begin
        top_digit = w_shf_digit[DIGITS-1];
        em_emit   = r_em_active && (r_em_seen || (top_digit != '0) || (r_em_pos == LAST_POS));
        out_free  = !r_out_valid || !i_stall;
        // skipped zeros advance without the output register
        em_adv    = r_em_active && (!em_emit || out_free);
        em_done   = em_adv && (r_em_pos == LAST_POS);
        em_ready  = !r_em_active || em_done;
        handoff   = r_cv_full && em_ready;
        cv_free   = !r_cv_busy && (!r_cv_full || handoff);
        in_acc    = i_valid && cv_free;
        start     = in_acc && (i_format == FMT_DECIMAL);

        dab_ctl.clear = start;
        dab_ctl.step  = r_cv_busy;
        shf_ctl.load  = handoff;
        shf_ctl.shift = em_adv;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cv_busy <= 1'b0;
            r_cv_full <= 1'b0;
            r_cv_cnt  <= '0;
        end else begin
            if (start) begin
                r_cv_busy <= 1'b1;
                r_cv_cnt  <= '0;
            end else if (r_cv_busy) begin
                r_cv_cnt <= r_cv_cnt + 1'b1;
                if (r_cv_cnt == LAST_STEP) begin
                    r_cv_busy <= 1'b0;
                end
            end
            if (r_cv_busy && (r_cv_cnt == LAST_STEP)) begin
                r_cv_full <= 1'b1;
            end else if (handoff) begin
                r_cv_full <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (start) begin
            r_cv_val <= i_value;
        end else if (r_cv_busy) begin
            r_cv_val <= {r_cv_val[VALUE_W-STEP_BITS-1:0], {STEP_BITS{1'b0}}};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_em_active <= 1'b0;
            r_em_seen   <= 1'b0;
            r_em_pos    <= '0;
        end else if (handoff) begin
            r_em_active <= 1'b1;
            r_em_seen   <= 1'b0;
            r_em_pos    <= '0;
        end else if (em_adv) begin
            r_em_pos  <= r_em_pos + 1'b1;
            r_em_seen <= r_em_seen || em_emit;
            if (r_em_pos == LAST_POS) begin
                r_em_active <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (em_adv && em_emit) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (em_adv && em_emit) begin
            r_out_char <= ASCII_ZERO + {{(CHAR_W-DIGIT_W){1'b0}}, top_digit};
            r_out_last <= (r_em_pos == LAST_POS);
        end
    end

    assign o_stall      = !cv_free;
    assign o_valid      = r_out_valid;
    assign o_digit_char = r_out_char;
    assign o_last       = r_out_last;

    `include "binary_to_decimal_ascii_macros.svh"

    `B2DA_ASSERT_NOW(a_cv_excl, i_clk, i_rst_n, 1'b1,
        !(r_cv_busy && r_cv_full), "converter busy and full at once")
    `B2DA_ASSERT_NOW(a_char_range, i_clk, i_rst_n, r_out_valid,
        (r_out_char >= ASCII_ZERO) && (r_out_char <= ASCII_NINE), "character outside 0..9")
    `B2DA_ASSERT_NOW(a_run_open, i_clk, i_rst_n, r_out_valid && !r_out_last,
        r_em_active, "run ended without a final character")
    `B2DA_ASSERT_NEXT(a_start_step, i_clk, i_rst_n, start,
        r_cv_busy && (r_cv_cnt == '0), "conversion did not begin")
    `B2DA_ASSERT_NEXT(a_em_wrap, i_clk, i_rst_n, em_done,
        !r_em_active || (r_em_pos == '0), "emitter did not wrap after last position")

endmodule

`default_nettype wire

/* rtl/b2da_dabble_cell.sv */
// One BCD digit of the double-dabble chain; four bits shifted per step.
// Depends on b2da_pkg.
`default_nettype none

module b2da_dabble_cell (
    input  wire                   i_clk,
    input  b2da_pkg::t_dab_ctl    i_ctl,
    input  b2da_pkg::t_step_bits  i_bits,
    output b2da_pkg::t_step_bits  o_bits,
    output b2da_pkg::t_digit      o_digit
);
    import b2da_pkg::*;

    t_digit r_digit;
    t_digit n_digit;

    // bit j of i_bits enters at sub-step j; the carry out of each sub-step
    // is the top bit of the adjusted digit, so it waits only on earlier bits of i_bits
    always_comb begin
        t_digit d;
        t_digit adj;
        d      = r_digit;
        o_bits = '0;
        for (int j = 0; j < STEP_BITS; j++) begin
            adj       = (d >= 4'd5) ? d + 4'd3 : d;
            o_bits[j] = adj[DIGIT_W-1];
            d         = {adj[DIGIT_W-2:0], i_bits[j]};
        end
        n_digit = d;
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.clear) begin
            r_digit <= '0;
        end else if (i_ctl.step) begin
            r_digit <= n_digit;
        end
    end

    assign o_digit = r_digit;

endmodule

`default_nettype wire

/* rtl/b2da_shift_cell.sv */
// One digit of the output shift line, loaded in parallel, shifted toward the top.
// Depends on b2da_pkg.
`default_nettype none

module b2da_shift_cell (
    input  wire                 i_clk,
    input  b2da_pkg::t_shf_ctl  i_ctl,
    input  b2da_pkg::t_digit    i_load_digit,
    input  b2da_pkg::t_digit    i_shift_digit,
    output b2da_pkg::t_digit    o_digit
);
    import b2da_pkg::*;

    t_digit r_digit;

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_digit <= i_load_digit;
        end else if (i_ctl.shift) begin
            r_digit <= i_shift_digit;
        end
    end

    assign o_digit = r_digit;

endmodule

`default_nettype wire
